>>> design/average_true_range_top_macros.svh
// ----------------------------------------------------------------------------
// Average true range assertion macros
// Shared property templates for the checker of the average true range block.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_TRUE_RANGE_TOP_MACROS_SVH
`define AVERAGE_TRUE_RANGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/atr_pkg.sv
// ----------------------------------------------------------------------------
// Average true range package
// Widths, register map, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package atr_pkg;

	localparam int PRICE_BITS     = 32;
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int WL_BITS        = 11;
	localparam int SUM_BITS       = 42;
	localparam int REM_BITS       = 10;
	localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);
	localparam int S_DATA_BITS    = 3 * PRICE_BITS;
	localparam int M_DATA_BITS    = ((PRICE_BITS + REM_BITS + 7) / 8) * 8;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 1;

	localparam logic [WL_BITS-1:0]       WL_RESET    = WL_BITS'(14);
	localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_SUM,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

>>> design/average_true_range_top.sv
// ----------------------------------------------------------------------------
// Average true range top level
// Computes the true range of each price bar, keeps the last window_length
// ranges in a ring memory with a running sum, and divides the sum by the
// window length with a radix-2 restoring divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: high_price, low_price, close_price
//  m_axis    out        tdata: average_range, division_remainder; tuser: window_full
//  apb       in/out     window_length at byte address 0
//
// Each bar passes through the ring memory read, the true range, the sum
// update and write back, the divider and the hand-over of the result to the
// output register before the next input beat is taken. The result waits
// there while the next bar is taken. A stalled output holds the sequencer
// in its last step.
// Reset empties the window and sets window_length to 14.
// ----------------------------------------------------------------------------
module average_true_range_top
	import atr_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// high_price [31:0], low_price [63:32], close_price [95:64]
	input  logic [S_DATA_BITS-1:0]   s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// average_range [31:0], division_remainder [41:32], zero [47:42]
	output logic [M_DATA_BITS-1:0]   m_axis_tdata,
	// window_full [0]
	output logic                     m_axis_tuser,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEN_CAP = (MAX_WINDOW > 2047) ? 2047 : MAX_WINDOW;
	localparam int CW      = ((AW > WL_BITS) ? AW : WL_BITS) + 1;

	state_t state_q, state_d;

	logic [WL_BITS-1:0]    wl_q;
	logic [WL_BITS-1:0]    len;
	logic [PRICE_BITS-1:0] prev_close_q;
	logic                  have_prev_q;
	logic [AW-1:0]         wp_q;
	logic [WL_BITS-1:0]    fill_q;
	logic [SUM_BITS-1:0]   sum_q;

	logic [PRICE_BITS-1:0] hi_q, lo_q, cl_q;
	logic [AW-1:0]         pos_q;
	logic [AW-1:0]         pos_cur;
	logic [PRICE_BITS-1:0] rd_data_q;
	logic [PRICE_BITS-1:0] old_q;
	logic [PRICE_BITS-1:0] tr_q;
	logic [PRICE_BITS-1:0] tr_d;
	logic [PRICE_BITS-1:0] hl, g1, g2;

	logic [PRICE_BITS-1:0] mem [MAX_WINDOW];

	logic                  full_before;
	logic [SUM_BITS-1:0]   sum_next;
	logic [WL_BITS-1:0]    fill_next;
	logic [CW-1:0]         pos_inc;
	logic                  full_s;

	logic [WL_BITS-1:0]    div_rem_q;
	logic [SUM_BITS-1:0]   div_quo_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic [WL_BITS:0]      div_shift;
	logic                  div_ge;
	logic                  div_last;

	logic                  out_valid_q;
	logic [PRICE_BITS-1:0] out_avg_q;
	logic [REM_BITS-1:0]   out_rem_q;
	logic                  out_full_q;

	logic                  in_accept;
	logic                  cfg_we;
	logic                  sum_en;
	logic                  calc_en;
	logic                  div_en;
	logic                  out_load;

	assign pready = 1'b1;
	assign prdata = {{(APB_DATA_BITS-WL_BITS){1'b0}}, wl_q};
	assign cfg_we = psel & penable & pwrite & pready & (paddr == ADDR_WINDOW);

	always_comb begin
		len = (wl_q == '0) ? WL_BITS'(1) : wl_q;
		if (len > WL_BITS'(LEN_CAP)) begin
			len = WL_BITS'(LEN_CAP);
		end
	end

	assign pos_cur = (CW'(wp_q) >= CW'(len)) ? '0 : wp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		calc_en       = 1'b0;
		sum_en        = 1'b0;
		div_en        = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_CALC: calc_en       = 1'b1;
			ST_SUM:  sum_en        = 1'b1;
			ST_DIV:  div_en        = 1'b1;
			ST_FIN:  out_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_accept = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// True range of the captured bar.
	always_comb begin
		hl = (hi_q >= lo_q) ? (hi_q - lo_q) : '0;
		g1 = (hi_q >= prev_close_q) ? (hi_q - prev_close_q) : (prev_close_q - hi_q);
		g2 = (prev_close_q >= lo_q) ? (prev_close_q - lo_q) : (lo_q - prev_close_q);
		tr_d = hl;
		if (have_prev_q) begin
			if (g1 > tr_d) begin
				tr_d = g1;
			end
			if (g2 > tr_d) begin
				tr_d = g2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			hi_q  <= s_axis_tdata[PRICE_BITS-1:0];
			lo_q  <= s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS];
			cl_q  <= s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
			pos_q <= pos_cur;
		end
		if (calc_en) begin
			tr_q  <= tr_d;
			old_q <= rd_data_q;
		end
	end

	// Ring memory of true ranges.
	always_ff @(posedge clk) begin
		if (sum_en) begin
			mem[pos_q] <= tr_q;
		end
		if (in_accept) begin
			rd_data_q <= mem[pos_cur];
		end
	end

	assign full_before = (fill_q >= len);
	assign sum_next    = sum_q - (full_before ? SUM_BITS'(old_q) : '0) + SUM_BITS'(tr_q);
	assign fill_next   = full_before ? fill_q : fill_q + WL_BITS'(1);
	assign pos_inc     = CW'(pos_q) + CW'(1);
	assign full_s      = (fill_next >= len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q         <= WL_RESET;
			prev_close_q <= '0;
			have_prev_q  <= 1'b0;
			wp_q         <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
		end else begin
			if (cfg_we) begin
				wl_q   <= pwdata[WL_BITS-1:0];
				wp_q   <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end else if (sum_en) begin
				wp_q   <= (pos_inc >= CW'(len)) ? '0 : pos_inc[AW-1:0];
				fill_q <= fill_next;
				sum_q  <= sum_next;
			end
			if (calc_en) begin
				prev_close_q <= cl_q;
				have_prev_q  <= 1'b1;
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign div_shift = {div_rem_q, div_quo_q[SUM_BITS-1]};
	assign div_ge    = (div_shift >= {1'b0, len});
	assign div_last  = (div_cnt_q == DIV_CNT_BITS'(SUM_BITS - 1));

	always_ff @(posedge clk) begin
		if (sum_en) begin
			div_rem_q  <= '0;
			div_quo_q  <= sum_next;
			out_full_q <= full_s;
		end else if (div_en) begin
			div_rem_q <= div_ge ? WL_BITS'(div_shift - {1'b0, len}) : div_shift[WL_BITS-1:0];
			div_quo_q <= {div_quo_q[SUM_BITS-2:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (sum_en) begin
			div_cnt_q <= '0;
		end else if (div_en) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q    <= div_quo_q[PRICE_BITS-1:0];
			out_rem_q    <= div_rem_q[REM_BITS-1:0];
			m_axis_tuser <= out_full_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_DATA_BITS-PRICE_BITS-REM_BITS){1'b0}}, out_rem_q, out_avg_q};

endmodule

>>> design/atr_checker.sv
// ----------------------------------------------------------------------------
// Average true range port checker
// Watches the ports of the top level and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "average_true_range_top_macros.svh"

module atr_checker
	import atr_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_axis_tvalid,
	input logic                     s_axis_tready,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [M_DATA_BITS-1:0]   m_axis_tdata,
	input logic                     m_axis_tuser,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [APB_ADDR_BITS-1:0] paddr,
	input logic [APB_DATA_BITS-1:0] pwdata,
	input logic [APB_DATA_BITS-1:0] prdata,
	input logic                     pready
);

	// A stalled output beat keeps its contents.
	`ATR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

	// A bar is worked on alone, so the input closes right after a beat.
	`ATR_ASSERT_NEXT(a_one_bar, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted beat")

	// A write to the window length register reads back on the next cycle.
	`ATR_ASSERT_NEXT(a_wl_readback, clk, arst_n, psel && penable && pwrite && pready && (paddr == ADDR_WINDOW), prdata == {{(APB_DATA_BITS-WL_BITS){1'b0}}, $past(pwdata[WL_BITS-1:0])}, "window length read back differs from the written value")

	// A window of one bar divides without remainder.
	`ATR_ASSERT_SAME(a_unit_rem, clk, arst_n, m_axis_tvalid && (prdata[WL_BITS-1:0] == WL_BITS'(0) || prdata[WL_BITS-1:0] == WL_BITS'(1)), m_axis_tdata[PRICE_BITS+REM_BITS-1:PRICE_BITS] == '0, "nonzero remainder for a window of one bar")

endmodule

bind average_true_range_top atr_checker u_atr_checker (.*);

>>> test/average_true_range_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Average true range testbench
// Streams price bars through the block under several window lengths, from
// the smallest to beyond the largest, and checks every result beat against a
// local prediction of the windowed true range sum, quotient and remainder.
// ----------------------------------------------------------------------------
module average_true_range_top_test;
	import atr_pkg::*;

	typedef struct packed {
		logic [PRICE_BITS-1:0] close_price;
		logic [PRICE_BITS-1:0] low_price;
		logic [PRICE_BITS-1:0] high_price;
	} bar_t;

	typedef struct {
		logic [PRICE_BITS-1:0] average_range;
		logic [REM_BITS-1:0]   division_remainder;
		logic                  window_full;
	} average_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// high_price [31:0], low_price [63:32], close_price [95:64]
	logic [S_DATA_BITS-1:0]   s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// average_range [31:0], division_remainder [41:32], zero [47:42]
	logic [M_DATA_BITS-1:0]   m_axis_tdata;
	// window_full [0]
	logic                     m_axis_tuser;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	bar_t     bars_to_send[$];
	average_t averages_due[$];
	int       error_count = 0;
	bit       steady = 1'b0;
	int       results_seen = 0;
	int       hold_off_left = 0;

	logic [WL_BITS-1:0]    window_setting = WL_RESET;
	logic [PRICE_BITS-1:0] last_close = '0;
	bit                    close_seen = 1'b0;
	logic [PRICE_BITS-1:0] range_ring [MAX_WINDOW_DEF];
	int unsigned           ring_pos = 0;
	int unsigned           bars_in_window = 0;
	logic [SUM_BITS-1:0]   range_total = '0;
	logic [PRICE_BITS-1:0] price_level = 32'd1_000_000;

	average_true_range_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [PRICE_BITS-1:0] abs_diff(logic [PRICE_BITS-1:0] a,
			logic [PRICE_BITS-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic average_t average_next_bar(bar_t bar);
		int unsigned           len;
		int unsigned           slot;
		logic [PRICE_BITS-1:0] span;
		logic [PRICE_BITS-1:0] gap;
		average_t              res;
		len = (window_setting == 0) ? 1 : int'(window_setting);
		if (len > MAX_WINDOW_DEF) begin
			len = MAX_WINDOW_DEF;
		end
		span = (bar.high_price >= bar.low_price) ? bar.high_price - bar.low_price : '0;
		if (close_seen) begin
			gap = abs_diff(bar.high_price, last_close);
			if (gap > span) begin
				span = gap;
			end
			gap = abs_diff(last_close, bar.low_price);
			if (gap > span) begin
				span = gap;
			end
		end
		last_close = bar.close_price;
		close_seen = 1'b1;
		slot = (ring_pos >= len) ? 0 : ring_pos;
		if (bars_in_window >= len) begin
			range_total = range_total - SUM_BITS'(range_ring[slot]);
		end else begin
			bars_in_window++;
		end
		range_ring[slot] = span;
		range_total = range_total + SUM_BITS'(span);
		slot++;
		ring_pos = (slot >= len) ? 0 : slot;
		res.average_range = PRICE_BITS'(range_total / SUM_BITS'(len));
		res.division_remainder = REM_BITS'(range_total % SUM_BITS'(len));
		res.window_full = (bars_in_window >= len);
		return res;
	endfunction

	function automatic bar_t random_bar();
		int unsigned pick;
		bar_t        bar;
		logic [PRICE_BITS-1:0] a;
		logic [PRICE_BITS-1:0] b;
		pick = $urandom_range(99);
		if (pick < 70) begin
			if (pick < 3) begin
				price_level = $urandom;
			end
			price_level = price_level + $urandom_range(2000) - 1000;
			bar.high_price = price_level + $urandom_range(600);
			bar.low_price = price_level - $urandom_range(600);
			bar.close_price = price_level + $urandom_range(600) - 300;
		end else if (pick < 85) begin
			bar.high_price = $urandom;
			bar.low_price = $urandom;
			bar.close_price = $urandom;
		end else if (pick < 93) begin
			a = $urandom;
			b = $urandom;
			bar.high_price = (a < b) ? a : b;
			bar.low_price = (a < b) ? b : a;
			bar.close_price = $urandom;
		end else begin
			bar.high_price = $urandom_range(1) ? '1 : '0;
			bar.low_price = $urandom_range(1) ? '1 : '0;
			bar.close_price = $urandom_range(2) == 0 ? $urandom : ($urandom_range(1) ? '1 : '0);
		end
		return bar;
	endfunction

	task automatic set_window_length(logic [APB_DATA_BITS-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_WINDOW;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		window_setting = value[WL_BITS-1:0];
		ring_pos = 0;
		bars_in_window = 0;
		range_total = '0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (bars_to_send.size() != 0 || s_axis_tvalid || averages_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic send_random_bars(int count);
		repeat (count) begin
			bars_to_send.push_back(random_bar());
		end
		wait_drained();
	endtask

	// Bar source: a new beat is offered only once the previous one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				averages_due.push_back(average_next_bar(bar_t'(s_axis_tdata)));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (bars_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
					s_axis_tdata <= bars_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink: checks each beat and holds off once for a long stretch.
	always @(posedge clk) begin
		average_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (results_seen == 400) begin
					hold_off_left = 800;
				end
				if (averages_due.size() == 0) begin
					$error("result beat with no bar outstanding");
					error_count++;
				end else begin
					want = averages_due.pop_front();
					if (m_axis_tdata[PRICE_BITS-1:0] !== want.average_range) begin
						$error("average_range: expected %0d, got %0d", want.average_range,
							m_axis_tdata[PRICE_BITS-1:0]);
						error_count++;
					end
					if (m_axis_tdata[PRICE_BITS +: REM_BITS] !== want.division_remainder) begin
						$error("division_remainder: expected %0d, got %0d",
							want.division_remainder, m_axis_tdata[PRICE_BITS +: REM_BITS]);
						error_count++;
					end
					if (m_axis_tuser !== want.window_full) begin
						$error("window_full: expected %0d, got %0d", want.window_full,
							m_axis_tuser);
						error_count++;
					end
				end
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady || $urandom_range(99) >= 30;
			end
		end
	end

	initial begin
		#4ms;
		$display("average_true_range_top_test failed");
		$finish;
	end

	initial begin
		static int unsigned lengths [10] = '{1, 0, 2, 3, 7, 1024, 2047, 1025, 14, 100};
		static int          counts [10] = '{30, 20, 40, 40, 60, 50, 30, 20, 60, 250};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Default window of 14: first bar with low above high, extremes, gaps.
		bars_to_send.push_back('{close_price: 32'd15, low_price: 32'd20, high_price: 32'd10});
		bars_to_send.push_back('{close_price: 32'd70, low_price: 32'd50, high_price: 32'd100});
		bars_to_send.push_back('{close_price: '1, low_price: '0, high_price: '1});
		bars_to_send.push_back('{close_price: '0, low_price: '0, high_price: '0});
		bars_to_send.push_back('{close_price: '0, low_price: '1, high_price: '1});
		bars_to_send.push_back('{close_price: 32'd4, low_price: 32'd3, high_price: 32'd5});
		bars_to_send.push_back('{close_price: 32'd2000, low_price: 32'd900,
			high_price: 32'd1000});
		bars_to_send.push_back('{close_price: '0, low_price: 32'd2100, high_price: 32'd2500});
		bars_to_send.push_back('{close_price: 32'd50, low_price: 32'd100, high_price: 32'd10});
		bars_to_send.push_back('{close_price: 32'h5555_5555, low_price: 32'h5555_5555,
			high_price: 32'hAAAA_AAAA});
		bars_to_send.push_back('{close_price: 32'hAAAA_AAAA, low_price: 32'hAAAA_AAAA,
			high_price: 32'h5555_5555});
		bars_to_send.push_back('{close_price: '1, low_price: '1, high_price: '0});
		send_random_bars(8);

		for (int i = 0; i < 10; i++) begin
			set_window_length(lengths[i]);
			steady = (lengths[i] == 7);
			send_random_bars(counts[i]);
		end
		steady = 1'b0;
		set_window_length($urandom_range(40, 1));
		send_random_bars(100);
		set_window_length(32'hFFFF_F800 | 32'd1023);
		send_random_bars(30);

		repeat (100) @(posedge clk);
		if (error_count == 0 && averages_due.size() == 0) begin
			$display("average_true_range_top_test passed");
		end else begin
			$display("average_true_range_top_test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/atr_pkg.sv
design/average_true_range_top.sv
design/atr_checker.sv
test/average_true_range_top_test.sv
